### hdl/bounded_edit_distance_core_macros.svh
// ----------------------------------------------------------------------------
// bounded_edit_distance_core_macros.svh
// Assertion helpers shared by the edit distance core.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_EDIT_DISTANCE_CORE_MACROS_SVH
`define BOUNDED_EDIT_DISTANCE_CORE_MACROS_SVH

// same-cycle implication
`define BED_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define BED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Types and constants of the bounded edit distance core.
// ----------------------------------------------------------------------------
package bed_pkg;

	localparam int DIST_W  = 6;
	localparam int CH_W    = 8;
	localparam int MODE_W  = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SECOND  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

	// register word index (paddr above the byte offset)
	localparam logic [PADDR_W-3:0] REG_MAX_DIST = 1'd0;
	localparam logic [DIST_W-1:0]  MAX_DIST_RST = 6'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CH_W-1:0]   ch;
	} in_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} out_item_t;

	typedef struct packed {
		logic              init;
		logic              step;
		logic              first_row;
		logic [DIST_W-1:0] init_diag;
		logic [DIST_W-1:0] init_left;
		logic [DIST_W-1:0] up_col;
	} cell_ctrl_t;

	typedef struct packed {
		logic [DIST_W-1:0] value;
		logic [DIST_W-1:0] row_min;
	} cell_stat_t;

endpackage

### hdl/bed_ram.sv
// ----------------------------------------------------------------------------
// bed_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/bed_cell.sv
// ----------------------------------------------------------------------------
// bed_cell
// Shared table cell unit: one min-of-three update per step, with the
// left, diagonal and running row minimum held between steps.
// ----------------------------------------------------------------------------
module bed_cell (
	input  logic                      clk,
	input  bed_pkg::cell_ctrl_t       ctrl,
	input  logic [bed_pkg::CH_W-1:0]  ch_a,
	input  logic [bed_pkg::CH_W-1:0]  ch_b,
	input  logic [bed_pkg::DIST_W-1:0] up_mem,
	output bed_pkg::cell_stat_t       stat
);

	logic [bed_pkg::DIST_W-1:0] left_q, diag_q, min_q;
	logic [bed_pkg::DIST_W-1:0] up, del_v, ins_v, sub_v, m1, v;
	logic                       cost;

	always_comb begin
		// first row of the table is simply the column index
		up    = ctrl.first_row ? ctrl.up_col : up_mem;
		cost  = (ch_a != ch_b);
		del_v = left_q + bed_pkg::DIST_W'(1);
		ins_v = up + bed_pkg::DIST_W'(1);
		sub_v = diag_q + bed_pkg::DIST_W'(cost);
		m1    = (del_v < ins_v) ? del_v : ins_v;
		v     = (m1 < sub_v) ? m1 : sub_v;
		stat.value   = v;
		stat.row_min = (v < min_q) ? v : min_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			diag_q <= ctrl.init_diag;
			left_q <= ctrl.init_left;
			min_q  <= ctrl.init_left;
		end else if (ctrl.step) begin
			diag_q <= up;
			left_q <= v;
			min_q  <= stat.row_min;
		end
	end

endmodule

### hdl/bounded_edit_distance_core.sv
// ----------------------------------------------------------------------------
// bounded_edit_distance_core
// Loads two words a byte per item (mode 0: first word, mode 1: second word,
// mode 3: ignored) and on mode 2 returns their Levenshtein distance plus the
// overflow flag, then clears both words. A compute walks the table one entry
// per cycle through a single min-of-three cell unit, with an S_FETCH step
// before each row to fetch the first word's byte and re-read column one of
// the row RAM; an empty word skips the walk. The result then waits for the
// result slot. After each row, a row minimum above max_distance ends the
// work and max_distance+1 is reported. Characters past MAX_LEN are dropped
// and flagged. The core is not ready while a compute runs; a result waits in
// its own output register, so loads proceed while it is unread.
// max_distance lives at byte address 0 of the APB port (reset 3).
// ----------------------------------------------------------------------------
`include "bounded_edit_distance_core_macros.svh"

module bounded_edit_distance_core #(
	parameter int MAX_LEN = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bed_pkg::PADDR_W-1:0]   paddr,
	input  logic [bed_pkg::PDATA_W-1:0]   pwdata,
	output logic [bed_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bed_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bed_pkg::out_item_t            out_data
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int DW = bed_pkg::DIST_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_CELL  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [DW-1:0]       max_q;
	logic [LW-1:0]       len_a_q, len_b_q;
	logic                ovf_q;
	logic [AW-1:0]       i_q, jc_q;
	logic                first_row_q;
	logic                out_valid_q;
	bed_pkg::out_item_t  res_q, out_q;

	logic                in_fire, out_free, cfg_we, reg_hit;
	logic                a_full, b_full, row_end, last_row;
	logic [AW-1:0]       la_m1, lb_m1, rd_col;
	logic [LW-1:0]       la_dec, lb_dec;
	logic                wa_we, wb_we;
	logic [bed_pkg::CH_W-1:0] fw_rdata, sw_rdata;
	logic [DW-1:0]       row_rdata;
	bed_pkg::cell_ctrl_t cell_ctrl;
	bed_pkg::cell_stat_t cell_stat;

	// configuration port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[bed_pkg::PADDR_W-1:2] == bed_pkg::REG_MAX_DIST);
	assign cfg_we  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? bed_pkg::PDATA_W'(max_q) : '0;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign a_full   = (len_a_q >= LW'(MAX_LEN));
	assign b_full   = (len_b_q >= LW'(MAX_LEN));
	assign la_dec   = len_a_q - LW'(1);
	assign lb_dec   = len_b_q - LW'(1);
	assign la_m1    = la_dec[AW-1:0];
	assign lb_m1    = lb_dec[AW-1:0];
	assign row_end  = (jc_q == lb_m1);
	assign last_row = (i_q == la_m1);

	// read one column ahead of the cell; hold at the last column
	always_comb begin
		if (state_q == S_CELL) begin
			rd_col = row_end ? jc_q : jc_q + AW'(1);
		end else begin
			rd_col = '0;
		end
	end

	assign wa_we = in_fire && (in_data.mode == bed_pkg::MODE_FIRST) && !a_full;
	assign wb_we = in_fire && (in_data.mode == bed_pkg::MODE_SECOND) && !b_full;

	bed_ram #(.WIDTH(bed_pkg::CH_W), .DEPTH(MAX_LEN)) u_first_word (
		.clk   (clk),
		.we    (wa_we),
		.waddr (len_a_q[AW-1:0]),
		.wdata (in_data.ch),
		.raddr (i_q),
		.rdata (fw_rdata)
	);

	bed_ram #(.WIDTH(bed_pkg::CH_W), .DEPTH(MAX_LEN)) u_second_word (
		.clk   (clk),
		.we    (wb_we),
		.waddr (len_b_q[AW-1:0]),
		.wdata (in_data.ch),
		.raddr (rd_col),
		.rdata (sw_rdata)
	);

	// one row, entry k holds table column k+1; column 0 is implied by the row index
	bed_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_row (
		.clk   (clk),
		.we    (state_q == S_CELL),
		.waddr (jc_q),
		.wdata (cell_stat.value),
		.raddr (rd_col),
		.rdata (row_rdata)
	);

	always_comb begin
		cell_ctrl.init      = (state_q == S_FETCH);
		cell_ctrl.step      = (state_q == S_CELL);
		cell_ctrl.first_row = first_row_q;
		cell_ctrl.init_diag = DW'(i_q);
		cell_ctrl.init_left = DW'(i_q) + DW'(1);
		cell_ctrl.up_col    = DW'(jc_q) + DW'(1);
	end

	bed_cell u_cell (
		.clk    (clk),
		.ctrl   (cell_ctrl),
		.ch_a   (fw_rdata),
		.ch_b   (sw_rdata),
		.up_mem (row_rdata),
		.stat   (cell_stat)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_q       <= bed_pkg::MAX_DIST_RST;
			len_a_q     <= '0;
			len_b_q     <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			jc_q        <= '0;
			first_row_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= pwdata[DW-1:0];
			end
			// a new result may replace the one taken in the same cycle
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (in_data.mode)
							bed_pkg::MODE_FIRST: begin
								if (a_full) ovf_q <= 1'b1;
								else len_a_q <= len_a_q + LW'(1);
							end
							bed_pkg::MODE_SECOND: begin
								if (b_full) ovf_q <= 1'b1;
								else len_b_q <= len_b_q + LW'(1);
							end
							bed_pkg::MODE_COMPUTE: begin
								i_q         <= '0;
								first_row_q <= 1'b1;
								if (len_a_q == '0 || len_b_q == '0) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_FETCH;
								end
							end
							default: ;
						endcase
					end
				end
				S_FETCH: begin
					jc_q    <= '0;
					state_q <= S_CELL;
				end
				S_CELL: begin
					if (row_end) begin
						if (cell_stat.row_min > max_q || last_row) begin
							state_q <= S_DONE;
						end else begin
							i_q         <= i_q + AW'(1);
							first_row_q <= 1'b0;
							state_q     <= S_FETCH;
						end
					end else begin
						jc_q <= jc_q + AW'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						len_a_q     <= '0;
						len_b_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire && in_data.mode == bed_pkg::MODE_COMPUTE) begin
			res_q.overflow <= ovf_q;
			if (len_a_q == '0) begin
				res_q.distance <= DW'(len_b_q);
			end else begin
				res_q.distance <= DW'(len_a_q);
			end
		end
		if (state_q == S_CELL && row_end) begin
			if (cell_stat.row_min > max_q) begin
				res_q.distance <= max_q + DW'(1);
			end else begin
				res_q.distance <= cell_stat.value;
			end
		end
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	`BED_ASSERT_NEXT(a_busy_after_compute, clk, arst_n, in_fire && in_data.mode == bed_pkg::MODE_COMPUTE, !in_ready)
	`BED_ASSERT_SAME(a_cell_in_range, clk, arst_n, state_q == S_CELL, LW'(jc_q) < len_b_q && LW'(i_q) < len_a_q)
	`BED_ASSERT_NEXT(a_done_clears, clk, arst_n, state_q == S_DONE && out_free, out_valid && len_a_q == '0 && len_b_q == '0 && !ovf_q)

endmodule

### dv/bounded_edit_distance_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_edit_distance_core_tb
// Streams character loads and compute items into the edit distance core and
// checks each returned distance and overflow flag against a row-by-row
// Levenshtein predictor that applies the same cutoff. A short directed
// section is followed by random word pairs under several cutoff settings and
// idle/stall patterns.
// ----------------------------------------------------------------------------
module bounded_edit_distance_core_tb;

	localparam int WORD_MAX = 32;
	localparam logic [bed_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [bed_pkg::PADDR_W-1:0]  paddr = '0;
	logic [bed_pkg::PDATA_W-1:0]  pwdata = '0;
	logic [bed_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	bed_pkg::in_item_t            in_data = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	bed_pkg::out_item_t           out_data;

	bounded_edit_distance_core #(.MAX_LEN(WORD_MAX)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [bed_pkg::CH_W-1:0]   first_chars [WORD_MAX];
	logic [bed_pkg::CH_W-1:0]   second_chars [WORD_MAX];
	int                         first_len = 0;
	int                         second_len = 0;
	logic                       dropped_char = 1'b0;
	logic [bed_pkg::DIST_W-1:0] cutoff = bed_pkg::MAX_DIST_RST;

	bed_pkg::in_item_t  char_stream[$];
	bed_pkg::out_item_t expected_distances[$];
	bed_pkg::out_item_t oldest;
	int                 errors = 0;
	int                 queued_count = 0;
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;

	// Update the word copies for one accepted item; on compute, predict the
	// bounded distance the same way the core walks the table.
	function automatic void track_word_item(bed_pkg::in_item_t it);
		int                 prev_row [WORD_MAX+1];
		int                 cur_row [WORD_MAX+1];
		int                 row_min, v, predicted;
		bit                 cut;
		bed_pkg::out_item_t res;
		case (it.mode)
			bed_pkg::MODE_FIRST: begin
				if (first_len < WORD_MAX) first_chars[first_len++] = it.ch;
				else dropped_char = 1'b1;
			end
			bed_pkg::MODE_SECOND: begin
				if (second_len < WORD_MAX) second_chars[second_len++] = it.ch;
				else dropped_char = 1'b1;
			end
			bed_pkg::MODE_COMPUTE: begin
				cut = 0;
				if (first_len == 0) predicted = second_len;
				else if (second_len == 0) predicted = first_len;
				else begin
					for (int j = 0; j <= second_len; j++) prev_row[j] = j;
					for (int i = 0; i < first_len && !cut; i++) begin
						cur_row[0] = i + 1;
						row_min = cur_row[0];
						for (int j = 0; j < second_len; j++) begin
							v = prev_row[j] + ((first_chars[i] == second_chars[j]) ? 0 : 1);
							if (cur_row[j] + 1 < v) v = cur_row[j] + 1;
							if (prev_row[j+1] + 1 < v) v = prev_row[j+1] + 1;
							cur_row[j+1] = v;
							if (v < row_min) row_min = v;
						end
						for (int j = 0; j <= second_len; j++) prev_row[j] = cur_row[j];
						if (row_min > cutoff) cut = 1;
					end
					predicted = cut ? cutoff + 1 : prev_row[second_len];
				end
				res.distance = predicted[bed_pkg::DIST_W-1:0];
				res.overflow = dropped_char;
				expected_distances = {expected_distances, res};
				first_len = 0;
				second_len = 0;
				dropped_char = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) track_word_item(in_data);
			if (!in_valid || in_ready) begin
				if (char_stream.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= char_stream.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_distances.size() == 0) begin
					$display("%0t: unexpected result, expected none, got distance %0d overflow %0b",
						$time, out_data.distance, out_data.overflow);
					errors++;
				end else begin
					oldest = expected_distances.pop_front();
					if (out_data.distance !== oldest.distance) begin
						$display("%0t: distance mismatch, expected %0d, got %0d",
							$time, oldest.distance, out_data.distance);
						errors++;
					end
					if (out_data.overflow !== oldest.overflow) begin
						$display("%0t: overflow mismatch, expected %0b, got %0b",
							$time, oldest.overflow, out_data.overflow);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_item(logic [bed_pkg::MODE_W-1:0] m, logic [bed_pkg::CH_W-1:0] c);
		bed_pkg::in_item_t it;
		it.mode = m;
		it.ch = c;
		char_stream = {char_stream, it};
		if (m != MODE_UNUSED) queued_count++;
	endtask

	task automatic write_cutoff(logic [bed_pkg::DIST_W-1:0] value);
		logic [bed_pkg::PDATA_W-1:0] want;
		want = {{(bed_pkg::PDATA_W-bed_pkg::DIST_W){1'b0}}, value};
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {bed_pkg::REG_MAX_DIST, 2'b00};
		pwdata <= want;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cutoff = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (prdata !== want) begin
			$display("%0t: cutoff readback mismatch, expected %0d, got %0d",
				$time, want, prdata);
			errors++;
		end
	endtask

	// let everything drain; loads leave no result, so keep waiting after the last expected result
	task automatic drain();
		@(negedge clk);
		while (char_stream.size() > 0 || in_valid || expected_distances.size() > 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic int pick_word_length();
		int r;
		r = $urandom_range(99);
		if (r < 8) return 0;
		if (r < 85) return $urandom_range(8, 1);
		if (r < 96) return $urandom_range(WORD_MAX, 9);
		return $urandom_range(WORD_MAX + 4, WORD_MAX + 1);
	endfunction

	// one word pair with interleaved loads and a compute, sometimes broken up
	task automatic queue_word_pair();
		logic [bed_pkg::CH_W-1:0] wa[$];
		logic [bed_pkg::CH_W-1:0] wb[$];
		int                       la, lb, ia, ib, r;
		bit                       narrow, similar;
		if ($urandom_range(99) < 8)
			repeat ($urandom_range(3, 1))
				queue_item(bed_pkg::MODE_W'($urandom_range(3)),
					bed_pkg::CH_W'($urandom_range(255)));
		narrow = ($urandom_range(1) == 1);
		similar = ($urandom_range(99) < 50);
		la = pick_word_length();
		lb = pick_word_length();
		for (int k = 0; k < la; k++)
			wa = {wa, bed_pkg::CH_W'(narrow ? 8'h61 + $urandom_range(2)
				: $urandom_range(255))};
		for (int k = 0; k < lb; k++) begin
			if (similar && k < la && $urandom_range(99) < 80) wb = {wb, wa[k]};
			else wb = {wb, bed_pkg::CH_W'(narrow ? 8'h61 + $urandom_range(2)
				: $urandom_range(255))};
		end
		ia = 0;
		ib = 0;
		while (ia < la || ib < lb) begin
			if ($urandom_range(99) < 5)
				queue_item(MODE_UNUSED, bed_pkg::CH_W'($urandom_range(255)));
			if (ib >= lb || (ia < la && $urandom_range(1))) queue_item(bed_pkg::MODE_FIRST, wa[ia++]);
			else queue_item(bed_pkg::MODE_SECOND, wb[ib++]);
		end
		r = $urandom_range(99);
		if (r < 4) return;  // no compute: words carry over into the next pair
		if (r < 8)
			queue_item(bed_pkg::MODE_W'($urandom_range(3)), bed_pkg::CH_W'($urandom_range(255)));
		queue_item(bed_pkg::MODE_COMPUTE, bed_pkg::CH_W'($urandom_range(255)));
	endtask

	initial begin
		logic [bed_pkg::DIST_W-1:0] cutoffs [6];
		int                         phase_start;
		cutoffs[0] = 6'd32;
		cutoffs[1] = 6'd1;
		cutoffs[2] = bed_pkg::DIST_W'($urandom_range(30, 2));
		cutoffs[3] = 6'd31;
		cutoffs[4] = 6'd0;
		cutoffs[5] = bed_pkg::DIST_W'($urandom_range(32));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset cutoff of 3
		queue_item(bed_pkg::MODE_COMPUTE, 8'h00);   // both words empty
		queue_item(bed_pkg::MODE_FIRST, 8'h00);
		queue_item(bed_pkg::MODE_COMPUTE, 8'hFF);   // second word empty
		queue_item(bed_pkg::MODE_SECOND, 8'hFF);
		queue_item(bed_pkg::MODE_SECOND, 8'hFF);
		queue_item(MODE_UNUSED, 8'hA5);             // ignored
		queue_item(bed_pkg::MODE_COMPUTE, 8'h00);   // first word empty
		queue_item(bed_pkg::MODE_FIRST, 8'hFF);
		queue_item(bed_pkg::MODE_SECOND, 8'hFF);
		queue_item(bed_pkg::MODE_COMPUTE, 8'h5A);   // identical words
		for (int k = 0; k < 6; k++) begin
			queue_item(bed_pkg::MODE_FIRST, bed_pkg::CH_W'(8'h61 + k));
			queue_item(bed_pkg::MODE_SECOND, bed_pkg::CH_W'(8'h75 + k));
		end
		queue_item(bed_pkg::MODE_COMPUTE, 8'h00);   // early exit, reports 4
		drain();

		// zero cutoff: last value above it still reported when no row exceeds it
		write_cutoff(6'd0);
		queue_item(bed_pkg::MODE_FIRST, 8'h61);
		queue_item(bed_pkg::MODE_SECOND, 8'h61);
		queue_item(bed_pkg::MODE_SECOND, 8'h62);
		queue_item(bed_pkg::MODE_COMPUTE, 8'h00);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_cutoff(cutoffs[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			phase_start = queued_count;
			while (queued_count - phase_start < 70) queue_word_pair();
			// close off any words left open by a broken pair
			queue_item(bed_pkg::MODE_COMPUTE, bed_pkg::CH_W'($urandom_range(255)));
			drain();
		end

		// a stray result would show up within one full table walk
		repeat (1100) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#(20 * 1_500_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
